// File: hdl/sorted_priority_queue_assert.svh
// assertion helpers shared by the queue rtl
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/spq_pkg.sv
package spq_pkg;

   // result status codes
   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_REMOVED   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_UNDERFLOW = 2'd3;

   // operation codes carried in the mode field
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   // capacity limit register
   localparam int         LIMIT_WIDTH = 5;
   localparam logic [4:0] LIMIT_RESET = 5'd16;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } spq_ctrl_type;

endpackage

// File: hdl/spq_channels.sv
// request channel: one queue operation per transaction
interface spq_req_if #(
   parameter int DATA_WIDTH = 16,
   parameter int PRIO_WIDTH = 8
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [DATA_WIDTH-1:0] data_in;
   logic [PRIO_WIDTH-1:0]        priority_in;

   modport source (output valid, mode, data_in, priority_in, input ready);
   modport sink   (input valid, mode, data_in, priority_in, output ready);
endinterface

// response channel: one result per transaction
interface spq_rsp_if #(
   parameter int DATA_WIDTH = 16,
   parameter int PRIO_WIDTH = 8,
   parameter int COUNT_WIDTH = 5
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic signed [DATA_WIDTH-1:0] data_out;
   logic [PRIO_WIDTH-1:0]        priority_out;
   logic [COUNT_WIDTH-1:0]       entries_held;

   modport source (output valid, status, data_out, priority_out, entries_held, input ready);
   modport sink   (input valid, status, data_out, priority_out, entries_held, output ready);
endinterface

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue, one row of shifting cells kept in ascending priority.
// Request channel (req_chan): mode 0 enqueues data_in with priority_in, mode 1
// dequeues the entry with the smallest priority; equal priorities leave in
// arrival order. Response channel (rsp_chan): one result per request with
// status (inserted, removed, overflow, underflow), the removed data and
// priority (zero otherwise) and the number of entries held afterwards.
// csr_wr_en/csr_wr_data write the capacity limit (capacity capped at DEPTH); write
// it only while no transaction is in flight.
// The result appears in the output register in the cycle after the request is
// accepted. Throughput: one request per cycle while results are taken, since
// every cell compares against the new priority and shifts in the same cycle.
// A stalled receiver holds the result; req_chan.ready stays high while the
// output register is empty or being emptied, so at most one result waits.
// Reset (synchronous) empties the queue, drops any pending result and sets
// the capacity limit to 16; the cell contents are not cleared.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 16,
   parameter int PRIO_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   spq_req_if.sink                req_chan,
   spq_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [LIMIT_WIDTH-1:0] csr_wr_data
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   logic [PRIO_WIDTH-1:0]  rsp_prio_ff, rsp_prio_in;
   logic [COUNT_WIDTH-1:0] rsp_held_ff;

   logic         req_fire, full, empty;
   spq_ctrl_type ctrl;

   logic [PRIO_WIDTH-1:0] cell_prio  [DEPTH];
   logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic                  cell_gt    [DEPTH];

   // capacity limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // accept while the output register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign full  = (count_ff >= COUNT_WIDTH'(DEPTH)) ||
                  (CMP_WIDTH'(count_ff) >= CMP_WIDTH'(limit_ff));
   assign empty = (count_ff == '0);

   assign ctrl.insert = req_fire && (req_chan.mode == MODE_ENQUEUE) && !full;
   assign ctrl.remove = req_fire && (req_chan.mode == MODE_DEQUEUE) && !empty;

   // row of cells, slot 0 holds the next entry to be served
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PRIO_WIDTH-1:0] lp, rp;
      logic [DATA_WIDTH-1:0] ld, rd;
      logic                  lg;

      if (i == 0) begin : g_first
         assign lp = req_chan.priority_in;
         assign ld = req_chan.data_in;
         assign lg = 1'b0;
      end else begin : g_inner_left
         assign lp = cell_prio[i-1];
         assign ld = cell_data[i-1];
         assign lg = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rp = cell_prio[i];
         assign rd = cell_data[i];
      end else begin : g_inner_right
         assign rp = cell_prio[i+1];
         assign rd = cell_data[i+1];
      end

      spq_cell #(
         .INDEX       (i),
         .COUNT_WIDTH (COUNT_WIDTH),
         .DATA_WIDTH  (DATA_WIDTH),
         .PRIO_WIDTH  (PRIO_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .new_prio   (req_chan.priority_in),
         .new_data   (req_chan.data_in),
         .left_prio  (lp),
         .left_data  (ld),
         .left_gt    (lg),
         .right_prio (rp),
         .right_data (rd),
         .prio       (cell_prio[i]),
         .data       (cell_data[i]),
         .gt         (cell_gt[i])
      );
   end

   // fill count and result for the accepted transaction
   always_comb begin
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_prio_in   = '0;
      if (req_chan.mode == MODE_ENQUEUE) begin
         rsp_status_in = full ? ST_OVERFLOW : ST_INSERTED;
         if (ctrl.insert) begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         rsp_status_in = empty ? ST_UNDERFLOW : ST_REMOVED;
         if (ctrl.remove) begin
            count_in    = count_ff - 1'b1;
            rsp_data_in = cell_data[0];
            rsp_prio_in = cell_prio[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire) begin
         count_ff <= count_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_held_ff   <= count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.data_out     = rsp_data_ff;
   assign rsp_chan.priority_out = rsp_prio_ff;
   assign rsp_chan.entries_held = rsp_held_ff;

   // checks
   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_WIDTH'(DEPTH), "fill count above depth")
   `SPQ_ASSERT_NOW(a_head_sorted, count_ff >= COUNT_WIDTH'(2),
      cell_prio[0] <= cell_prio[1], "head cells out of order")
   `SPQ_ASSERT_NEXT(a_remove_count, ctrl.remove,
      count_ff == $past(count_ff) - 1'b1, "removal did not lower count")
   `SPQ_ASSERT_NEXT(a_insert_count, ctrl.insert,
      count_ff == $past(count_ff) + 1'b1, "insertion did not raise count")

endmodule

// File: hdl/spq_cell.sv
module spq_cell import spq_pkg::*; #(
   parameter int INDEX       = 0,
   parameter int COUNT_WIDTH = 5,
   parameter int DATA_WIDTH  = 16,
   parameter int PRIO_WIDTH  = 8
) (
   input  logic                   clock,
   input  spq_ctrl_type           ctrl,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [PRIO_WIDTH-1:0]  new_prio,
   input  logic [DATA_WIDTH-1:0]  new_data,
   input  logic [PRIO_WIDTH-1:0]  left_prio,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic                   left_gt,
   input  logic [PRIO_WIDTH-1:0]  right_prio,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [PRIO_WIDTH-1:0]  prio,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   gt
);

   logic [PRIO_WIDTH-1:0] prio_ff, prio_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  occupied;

   // slot holds a live entry when it lies below the fill count
   assign occupied = count > COUNT_WIDTH'(INDEX);
   // live entry that must move up to make room for the new one
   assign gt       = occupied && (prio_ff > new_prio);

   assign prio = prio_ff;
   assign data = data_ff;

   // shift up, take the new entry, shift down or hold
   always_comb begin
      prio_in = prio_ff;
      data_in = data_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            prio_in = left_prio;
            data_in = left_data;
         end else if (gt || !occupied) begin
            prio_in = new_prio;
            data_in = new_data;
         end
      end else if (ctrl.remove) begin
         prio_in = right_prio;
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

endmodule
